// ----- hw/rtl/rsmc_pkg.sv -----
// ----------------------------------------------------------------------------
// rsmc_pkg: shared definitions for the record stack
// Request and status codes, field widths, control struct and a saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package rsmc_pkg;

  localparam int STACK_DEPTH_DEF = 128;

  localparam int REQ_W   = 2;
  localparam int SIZE_W  = 16;
  localparam int AGE_W   = 8;
  localparam int STAT_W  = 2;
  localparam int OCNT_W  = 8;
  localparam int REC_W   = SIZE_W + AGE_W;

  localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_COUNT = 2'd2;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic clr;
    logic en;
  } match_ctl_t;

  function automatic logic [OCNT_W-1:0] sat8(input logic [31:0] v);
    logic [OCNT_W-1:0] r;
    if (v > 32'd255) begin
      r = 8'd255;
    end else begin
      r = v[OCNT_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/rsmc_ram.sv -----
// ----------------------------------------------------------------------------
// rsmc_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rsmc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rsmc_match.sv -----
// ----------------------------------------------------------------------------
// rsmc_match: shared age compare and match accumulator
// Compares one stored age per cycle against the key and counts hits.
// ----------------------------------------------------------------------------
`default_nettype none

module rsmc_match #(
  parameter int CNT_W = 8
) (
  input  wire logic                     clk,
  input  wire rsmc_pkg::match_ctl_t     ctl,
  input  wire logic [rsmc_pkg::AGE_W-1:0] rec_age,
  input  wire logic [rsmc_pkg::AGE_W-1:0] key_age,
  output logic      [CNT_W-1:0]         count_nxt
);

  logic [CNT_W-1:0] count_r;
  logic             hit;

  assign hit = ctl.en && (rec_age == key_age);

  always_comb begin
    if (ctl.clr) begin
      count_nxt = '0;
    end else begin
      count_nxt = count_r + CNT_W'(hit);
    end
  end

  always_ff @(posedge clk) begin
    count_r <= count_nxt;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/record_stack_with_match_count_top.sv -----
// ----------------------------------------------------------------------------
// record_stack_with_match_count_top: bounded record stack with age counter
// Push, pop and count-by-age requests over a RAM-backed LIFO.
// ----------------------------------------------------------------------------
// Usage:
//   A request transaction is taken when start is high and busy is low.
//   Every request gives exactly one result, shown for one cycle with
//   out_valid high; the receiver cannot stall, so results are never held.
//   Push and the unused request kind: result in the cycle after acceptance,
//     busy stays low, so one such request per cycle is sustained.
//   Pop: one RAM read, busy in S_POP; read data and result are registered.
//     Pop on an empty stack: result in the cycle after acceptance, no busy.
//   Count: walks the stored records through the single RAM read port and
//     the shared compare unit, one record per cycle; busy until the last
//     record is compared; result in the cycle after acceptance when empty.
//   out_depth_now and out_match_count saturate at 255.
//   Reset empties the stack by clearing the fill level; the RAM is not
//   cleared, since no entry above the fill level is ever used.
// ----------------------------------------------------------------------------
`default_nettype none

module record_stack_with_match_count_top #(
  parameter int STACK_DEPTH = rsmc_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [rsmc_pkg::REQ_W-1:0]    in_req_type,
  input  wire logic [rsmc_pkg::SIZE_W-1:0]   in_item_size,
  input  wire logic [rsmc_pkg::AGE_W-1:0]    in_item_age,
  output logic                               out_valid,
  output logic [rsmc_pkg::STAT_W-1:0]        out_status,
  output logic [rsmc_pkg::SIZE_W-1:0]        out_popped_size,
  output logic [rsmc_pkg::AGE_W-1:0]         out_popped_age,
  output logic [rsmc_pkg::OCNT_W-1:0]        out_match_count,
  output logic [rsmc_pkg::OCNT_W-1:0]        out_depth_now
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_POP   = 2'd1;
  localparam logic [1:0] S_COUNT = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] fill_dec;
  logic [rsmc_pkg::AGE_W-1:0] key_r, key_nxt;

  logic                         valid_r, valid_nxt;
  logic [rsmc_pkg::STAT_W-1:0]  status_r, status_nxt;
  logic [rsmc_pkg::SIZE_W-1:0]  psize_r, psize_nxt;
  logic [rsmc_pkg::AGE_W-1:0]   page_r, page_nxt;
  logic [rsmc_pkg::OCNT_W-1:0]  mcnt_r, mcnt_nxt;
  logic [rsmc_pkg::OCNT_W-1:0]  depth_r, depth_nxt;

  logic                         accept;
  logic                         full;
  logic                         ram_we;
  logic [AW-1:0]                ram_raddr;
  logic [rsmc_pkg::REC_W-1:0]   ram_wdata, ram_rdata;
  rsmc_pkg::match_ctl_t         mctl;
  logic [CW-1:0]                count_nxt;

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign full     = (fill_r == CW'(STACK_DEPTH));
  assign fill_dec = fill_r - CW'(1);
  assign ram_we   = accept && (in_req_type == rsmc_pkg::REQ_PUSH) && !full;
  assign ram_wdata = {in_item_size, in_item_age};

  always_comb begin
    if (state_r == S_COUNT) begin
      ram_raddr = idx_r[AW-1:0];
    end else if (accept && (in_req_type == rsmc_pkg::REQ_POP)) begin
      ram_raddr = fill_dec[AW-1:0];
    end else begin
      ram_raddr = '0;
    end
  end

  rsmc_ram #(
    .WIDTH(rsmc_pkg::REC_W),
    .DEPTH(STACK_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(fill_r[AW-1:0]),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign mctl.clr = accept;
  assign mctl.en  = (state_r == S_COUNT);

  rsmc_match #(
    .CNT_W(CW)
  ) u_match (
    .clk      (clk),
    .ctl      (mctl),
    .rec_age  (ram_rdata[rsmc_pkg::AGE_W-1:0]),
    .key_age  (key_r),
    .count_nxt(count_nxt)
  );

  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    idx_nxt    = idx_r;
    key_nxt    = key_r;
    valid_nxt  = 1'b0;
    status_nxt = rsmc_pkg::ST_DONE;
    psize_nxt  = '0;
    page_nxt   = '0;
    mcnt_nxt   = '0;
    depth_nxt  = rsmc_pkg::sat8(32'(fill_r));
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          key_nxt = in_item_age;
          case (in_req_type)
            rsmc_pkg::REQ_PUSH: begin
              valid_nxt = 1'b1;
              if (full) begin
                status_nxt = rsmc_pkg::ST_FULL;
              end else begin
                fill_nxt  = fill_r + CW'(1);
                depth_nxt = rsmc_pkg::sat8(32'(fill_nxt));
              end
            end
            rsmc_pkg::REQ_POP: begin
              if (fill_r == '0) begin
                valid_nxt  = 1'b1;
                status_nxt = rsmc_pkg::ST_EMPTY;
              end else begin
                fill_nxt  = fill_dec;
                state_nxt = S_POP;
              end
            end
            rsmc_pkg::REQ_COUNT: begin
              if (fill_r == '0) begin
                valid_nxt = 1'b1;
              end else begin
                idx_nxt   = CW'(1);
                state_nxt = S_COUNT;
              end
            end
            default: begin
              valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        valid_nxt = 1'b1;
        psize_nxt = ram_rdata[rsmc_pkg::REC_W-1:rsmc_pkg::AGE_W];
        page_nxt  = ram_rdata[rsmc_pkg::AGE_W-1:0];
        state_nxt = S_IDLE;
      end
      S_COUNT: begin
        if (idx_r == fill_r) begin
          valid_nxt = 1'b1;
          mcnt_nxt  = rsmc_pkg::sat8(32'(count_nxt));
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    key_r    <= key_nxt;
    status_r <= status_nxt;
    psize_r  <= psize_nxt;
    page_r   <= page_nxt;
    mcnt_r   <= mcnt_nxt;
    depth_r  <= depth_nxt;
  end

  assign out_valid       = valid_r;
  assign out_status      = status_r;
  assign out_popped_size = psize_r;
  assign out_popped_age  = page_r;
  assign out_match_count = mcnt_r;
  assign out_depth_now   = depth_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(STACK_DEPTH))
    else $error("fill level above stack depth");

  a_push_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_req_type == rsmc_pkg::REQ_PUSH) |=> valid_r && (state_r == S_IDLE))
    else $error("push did not complete in one cycle");

  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_POP |=> valid_r && (state_r == S_IDLE))
    else $error("pop result missing");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_COUNT |-> (idx_r <= fill_r) && (idx_r != '0))
    else $error("count walk index out of range");

  a_no_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COUNT) && (idx_r != fill_r) |=> !valid_r)
    else $error("result strobed during count walk");

endmodule

`default_nettype wire
